FILE: hdl/bfa_pkg.sv
// Package for the best-fit block allocator: request and response transaction
// types, operation codes and fixed field widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bfa_pkg;

    localparam int SIZE_W = 12;
    localparam int OFFS_W = 12;
    localparam int CFG_W  = 13;

    localparam logic [CFG_W-1:0] POOL_MIN   = 13'd16;
    localparam logic [CFG_W-1:0] POOL_RESET = 13'd4096;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [SIZE_W-1:0] request_size;
        logic [OFFS_W-1:0] block_offset;
    } t_bfa_req;

    typedef struct packed {
        logic              ok;
        logic [OFFS_W-1:0] payload_offset;
    } t_bfa_rsp;

endpackage

`default_nettype wire

FILE: hdl/bfa_header_ram.sv
// Header store of the best-fit block allocator: one write port, one read port,
// registered read data. No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module bfa_header_ram #(
    parameter int AW = 12,
    parameter int DW = 14
) (
    input  wire                  i_clk,
    input  wire                  i_we,
    input  wire  [AW-1:0]        i_waddr,
    input  wire  signed [DW-1:0] i_wdata,
    input  wire  [AW-1:0]        i_raddr,
    output logic signed [DW-1:0] o_rdata
);

    logic signed [DW-1:0] r_mem [0:(1 << AW)-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/best_fit_block_allocator.sv
// Best-fit block allocator over a byte pool kept as an implicit block list.
// Depends on bfa_pkg and bfa_header_ram.
`timescale 1ns / 1ps
`default_nettype none

// The pool is a chain of blocks, each led by a signed header held in a
// synchronous memory indexed by byte offset: a positive header is a free block
// of that many payload bytes, a negative one an allocated block. An allocate
// transaction walks every block and takes the smallest free block whose payload
// exceeds the request plus one header, splits it and returns the payload offset;
// a zero-size request or one that finds no block returns ok low and offset zero.
// A free transaction walks the chain to the header in front of the given
// offset, marks it free (ok low if no header sits there) and then walks the
// whole pool once more, merging each free block with the free blocks behind it.
// One request is in service at a time. Because every step of a walk needs the
// header just read to find the next one, the memory's registered read sets the
// pace of every walk. A result waits in an output register and the next
// request is taken as soon as the result has been moved there. Writing the
// pool size restarts the pool as one free block; this is also done once after
// reset. Only headers on the live chain are ever read, so the rest of the
// memory needs no clearing.

module best_fit_block_allocator
    import bfa_pkg::*;
#(
    parameter int POOL_BYTES   = 4096,
    parameter int HEADER_BYTES = 4
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  wire  t_bfa_req   i_in_req,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output t_bfa_rsp         o_out_rsp,
    input  wire              i_cfg_wr_en,
    input  wire  [CFG_W-1:0] i_cfg_wr_data
);

    // Byte addresses, header values and positions along the chain.
    localparam int AW = $clog2(POOL_BYTES);
    localparam int HW = AW + 2;
    localparam int PW = AW + 1;
    localparam int TW = (PW > CFG_W) ? PW : CFG_W;

    localparam logic [TW-1:0]        HB_T   = TW'(HEADER_BYTES);
    localparam logic signed [HW-1:0] HB_H   = HW'(HEADER_BYTES);
    localparam logic [TW-1:0]        PMAX_T = TW'(POOL_BYTES);
    localparam logic [TW-1:0]        PMIN_T = TW'(POOL_MIN);

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_A_RD    = 4'd2;
    localparam logic [3:0] S_A_EV    = 4'd3;
    localparam logic [3:0] S_A_SPLIT = 4'd4;
    localparam logic [3:0] S_A_MARK  = 4'd5;
    localparam logic [3:0] S_F_RD    = 4'd6;
    localparam logic [3:0] S_F_EV    = 4'd7;
    localparam logic [3:0] S_M_RD    = 4'd8;
    localparam logic [3:0] S_M_EV    = 4'd9;
    localparam logic [3:0] S_M_CHK   = 4'd10;
    localparam logic [3:0] S_M_NX    = 4'd11;
    localparam logic [3:0] S_DONE    = 4'd12;

    // Magnitude of a header, as a byte count along the chain.
    function automatic logic [TW-1:0] f_mag(input logic signed [HW-1:0] v);
        logic [HW-1:0] u;
        begin
            u = v[HW-1] ? -v : v;
            return TW'(u);
        end
    endfunction

    logic [3:0]           r_state, n_state;
    logic [CFG_W-1:0]     r_pool;
    logic [TW-1:0]        r_at, n_at;
    logic [TW-1:0]        r_best, n_best;
    logic [TW-1:0]        r_best_len, n_best_len;
    logic                 r_found, n_found;
    logic signed [HW-1:0] r_h, n_h;
    logic [SIZE_W-1:0]    r_size, n_size;
    logic [TW-1:0]        r_target, n_target;
    logic                 r_ok, n_ok;
    logic [OFFS_W-1:0]    r_off, n_off;
    logic                 r_out_valid;
    t_bfa_rsp             r_out_rsp;

    logic                 w_load;
    logic [TW-1:0]        w_pool_ext;
    logic [TW-1:0]        w_end;
    logic signed [HW-1:0] w_rdata;
    logic [TW-1:0]        w_hmag;
    logic                 w_hpos;
    logic [TW-1:0]        w_step;
    logic [TW-1:0]        w_need;
    logic                 w_better;
    logic [TW-1:0]        w_nx;
    logic                 w_rh_pos;
    logic [TW-1:0]        w_raddr;
    logic                 w_we;
    logic [TW-1:0]        w_waddr;
    logic signed [HW-1:0] w_wdata;
    logic signed [HW-1:0] w_merged;

    // Pool size in use, clamped to the legal range.
    assign w_pool_ext = TW'(r_pool);
    always_comb begin
        if (w_pool_ext < PMIN_T) begin
            w_end = PMIN_T;
        end else if (w_pool_ext > PMAX_T) begin
            w_end = PMAX_T;
        end else begin
            w_end = w_pool_ext;
        end
    end

    // Header just read and the position of the block behind it.
    assign w_hmag   = f_mag(w_rdata);
    assign w_hpos   = !w_rdata[HW-1] && (w_rdata != '0);
    assign w_step   = r_at + HB_T + w_hmag;
    assign w_need   = TW'(r_size) + HB_T;
    assign w_better = w_hpos && (w_hmag > w_need) && (!r_found || (w_hmag < r_best_len));

    // Merge pass works from the held header in r_h.
    assign w_rh_pos = !r_h[HW-1] && (r_h != '0);
    assign w_nx     = r_at + HB_T + f_mag(r_h);
    assign w_merged = r_h + HB_H + w_rdata;

    assign w_raddr = (r_state == S_M_CHK) ? w_nx : r_at;

    // The result register is free when empty or being taken this cycle.
    assign w_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state    = r_state;
        n_at       = r_at;
        n_best     = r_best;
        n_best_len = r_best_len;
        n_found    = r_found;
        n_h        = r_h;
        n_size     = r_size;
        n_target   = r_target;
        n_ok       = r_ok;
        n_off      = r_off;
        w_we       = 1'b0;
        w_waddr    = '0;
        w_wdata    = '0;

        case (r_state)
            S_INIT: begin
                // One free block spanning the whole pool.
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = HW'(w_end - HB_T);
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_at    = '0;
                    n_found = 1'b0;
                    n_ok    = 1'b0;
                    n_off   = '0;
                    n_size  = i_in_req.request_size;
                    if (i_in_req.operation == OP_ALLOC) begin
                        n_state = (i_in_req.request_size == '0) ? S_DONE : S_A_RD;
                    end else if (TW'(i_in_req.block_offset) < HB_T) begin
                        n_state = S_DONE;
                    end else begin
                        n_target = TW'(i_in_req.block_offset) - HB_T;
                        n_state  = S_F_RD;
                    end
                end
            end
            S_A_RD: begin
                n_state = S_A_EV;
            end
            S_A_EV: begin
                if (w_better) begin
                    n_found    = 1'b1;
                    n_best     = r_at;
                    n_best_len = w_hmag;
                end
                n_at = w_step;
                if (w_step >= w_end) begin
                    n_state = (r_found || w_better) ? S_A_SPLIT : S_DONE;
                end else begin
                    n_state = S_A_RD;
                end
            end
            S_A_SPLIT: begin
                // New free block behind the allocated front part.
                w_we    = 1'b1;
                w_waddr = r_best + HB_T + TW'(r_size);
                w_wdata = HW'(r_best_len - HB_T - TW'(r_size));
                n_state = S_A_MARK;
            end
            S_A_MARK: begin
                w_we    = 1'b1;
                w_waddr = r_best;
                w_wdata = -(HW'(r_size));
                n_ok    = 1'b1;
                n_off   = OFFS_W'(r_best + HB_T);
                n_state = S_DONE;
            end
            S_F_RD: begin
                n_state = S_F_EV;
            end
            S_F_EV: begin
                if (r_at == r_target) begin
                    w_we    = 1'b1;
                    w_waddr = r_target;
                    w_wdata = HW'(w_hmag);
                    n_at    = '0;
                    n_state = S_M_RD;
                end else if (r_at > r_target) begin
                    n_state = S_DONE;
                end else begin
                    n_at    = w_step;
                    n_state = (w_step >= w_end) ? S_DONE : S_F_RD;
                end
            end
            S_M_RD: begin
                n_state = S_M_EV;
            end
            S_M_EV: begin
                n_h     = w_rdata;
                n_state = S_M_CHK;
            end
            S_M_CHK: begin
                if (w_rh_pos && (w_nx < w_end)) begin
                    n_state = S_M_NX;
                end else if (w_nx >= w_end) begin
                    n_ok    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_at    = w_nx;
                    n_state = S_M_RD;
                end
            end
            S_M_NX: begin
                if (w_hpos) begin
                    w_we    = 1'b1;
                    w_waddr = r_at;
                    w_wdata = w_merged;
                    n_h     = w_merged;
                end else begin
                    // The header behind is already in hand, so step onto it.
                    n_at = w_nx;
                    n_h  = w_rdata;
                end
                n_state = S_M_CHK;
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase

        // A pool size write restarts the pool.
        if (i_cfg_wr_en) begin
            n_state = S_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_pool      <= POOL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_pool <= i_cfg_wr_data;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_at       <= n_at;
        r_best     <= n_best;
        r_best_len <= n_best_len;
        r_found    <= n_found;
        r_h        <= n_h;
        r_size     <= n_size;
        r_target   <= n_target;
        r_ok       <= n_ok;
        r_off      <= n_off;
        if (w_load) begin
            r_out_rsp.ok             <= r_ok;
            r_out_rsp.payload_offset <= r_off;
        end
    end

    bfa_header_ram #(
        .AW (AW),
        .DW (HW)
    ) u_header_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr[AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule

`default_nettype wire

FILE: hdl/bfa_checker.sv
// Port-level checks for the best-fit block allocator, bound to the top level.
// Depends on bfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfa_checker
    import bfa_pkg::*;
(
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             i_in_valid,
    input wire             o_in_stall,
    input wire t_bfa_req   i_in_req,
    input wire             o_out_valid,
    input wire             i_out_stall,
    input wire t_bfa_rsp   o_out_rsp,
    input wire             i_cfg_wr_en,
    input wire [CFG_W-1:0] i_cfg_wr_data
);

    // A waiting result holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_rsp))
        else $error("result changed while stalled");

    // A refused request never carries an offset.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_rsp.ok |-> o_out_rsp.payload_offset == '0)
        else $error("failed result with nonzero offset");

    // Only one request is in service: an accepted transaction blocks the next.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted again straight after a transaction");

    // A pool size write restarts the pool, which takes the block out of idle.
    a_busy_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> o_in_stall)
        else $error("input not stalled during pool restart");

endmodule

bind best_fit_block_allocator bfa_checker u_bfa_checker (.*);

`default_nettype wire

FILE: dv/tb_best_fit_block_allocator.sv
`timescale 1ns / 1ps
// Self-checking testbench for best_fit_block_allocator: directed and random
// allocate and free transactions checked against a shadow copy of the pool.
// Depends on bfa_pkg and the allocator RTL; needs no files or arguments.

module tb_best_fit_block_allocator;
    import bfa_pkg::*;

    // These match the block's default parameters, which the instance uses.
    localparam int POOL_MAX      = 4096;
    localparam int HDR_BYTES     = 4;
    // Quiet time after the last response, so that a spurious extra response
    // would still be caught before the run ends.
    localparam int SETTLE_CYCLES = 32;
    localparam int RANDOM_ITEMS  = 700;
    localparam int PHASES        = 7;
    localparam int MAX_REPORTS   = 40;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    t_bfa_req         in_req;
    logic             out_valid;
    logic             out_stall;
    t_bfa_rsp         out_rsp;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;

    best_fit_block_allocator #(
        .POOL_BYTES   (POOL_MAX),
        .HEADER_BYTES (HDR_BYTES)
    ) DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_req      (in_req),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_rsp     (out_rsp),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    // Shadow of the pool. Each entry is the signed header that would sit at
    // that byte offset: positive for a free block, negative for an allocated
    // one. Only entries on the live block chain are ever consulted.
    int       shadow_hdr [POOL_MAX];
    int       pool_len;
    // Payload offsets currently allocated, so that most frees are well formed.
    int       live_offsets [$];
    // Responses that the block owes us, oldest first.
    t_bfa_rsp pending_rsp [$];

    int mismatches    = 0;
    int results_seen  = 0;
    int allocs_ok     = 0;
    int allocs_failed = 0;
    int frees_ok      = 0;
    int frees_ignored = 0;
    int pool_writes   = 0;

    // When set, neither side inserts idle cycles.
    bit quiet_mode    = 1'b0;
    // Cycles for which the response side must hold off; counted down by the
    // stall driver itself.
    int hold_off_left = 0;

    initial begin : clock_gen
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin : run_limit
        // Far beyond the slowest legal run: every request walking a pool
        // packed with minimum-size blocks while both sides idle at length.
        #40_000_000;
        $display("FAIL best_fit_block_allocator");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shadow pool
    // ------------------------------------------------------------------

    function automatic int hdr_rd(int at);
        if (at < 0 || at >= POOL_MAX) return 0;
        return shadow_hdr[at];
    endfunction

    function automatic void hdr_wr(int at, int v);
        if (at >= 0 && at < POOL_MAX) shadow_hdr[at] = v;
    endfunction

    function automatic int magnitude(int v);
        return (v < 0) ? -v : v;
    endfunction

    // Writing the pool size clamps it into range and leaves a single free
    // block spanning the whole pool; every earlier allocation is forgotten.
    function automatic void restart_pool(logic [CFG_W-1:0] bytes);
        int p;
        p = int'(bytes);
        if (p < int'(POOL_MIN)) p = int'(POOL_MIN);
        if (p > POOL_MAX) p = POOL_MAX;
        pool_len = p;
        foreach (shadow_hdr[i]) shadow_hdr[i] = 0;
        shadow_hdr[0] = pool_len - HDR_BYTES;
        live_offsets.delete();
    endfunction

    // Best fit: the smallest free block whose payload strictly exceeds the
    // request plus one header. The front is taken, the tail stays free.
    function automatic bit best_fit_alloc(int size, output int where);
        int at;
        int h;
        int best;
        int best_len;
        bit found;
        at       = 0;
        best     = 0;
        best_len = 0;
        found    = 1'b0;
        where    = 0;
        if (size <= 0) return 1'b0;
        while (at < pool_len) begin
            h = hdr_rd(at);
            if (h > 0 && h > size + HDR_BYTES && (!found || h < best_len)) begin
                found    = 1'b1;
                best     = at;
                best_len = h;
            end
            at += HDR_BYTES + magnitude(h);
        end
        if (!found) return 1'b0;
        hdr_wr(best + HDR_BYTES + size, best_len - HDR_BYTES - size);
        hdr_wr(best, -size);
        where = best + HDR_BYTES;
        return 1'b1;
    endfunction

    // A free only takes effect if a header sits just in front of the offset.
    // Freeing an already free block is still served and still merges.
    function automatic bit release_block(int payload);
        int target;
        int at;
        int h;
        int nx;
        bit found;
        int hits [$];
        target = payload - HDR_BYTES;
        at     = 0;
        found  = 1'b0;
        if (target < 0) return 1'b0;
        while (at < pool_len && !found && at <= target) begin
            if (at == target) found = 1'b1;
            else at += HDR_BYTES + magnitude(hdr_rd(at));
        end
        if (!found) return 1'b0;
        hdr_wr(target, magnitude(hdr_rd(target)));
        // Merge pass: a free block swallows each free neighbour behind it.
        // The header past the last block lies beyond the pool and is skipped.
        at = 0;
        while (at < pool_len) begin
            h  = hdr_rd(at);
            nx = at + h + HDR_BYTES;
            if (h > 0 && nx < pool_len && hdr_rd(nx) > 0)
                hdr_wr(at, h + HDR_BYTES + hdr_rd(nx));
            else
                at += HDR_BYTES + magnitude(h);
        end
        hits = live_offsets.find_first_index(x) with (x == payload);
        if (hits.size() != 0) live_offsets.delete(hits[0]);
        return 1'b1;
    endfunction

    function automatic t_bfa_rsp predict_response(t_bfa_req r);
        t_bfa_rsp rsp;
        int       where;
        bit       served;
        where = 0;
        if (r.operation == OP_ALLOC) begin
            served = best_fit_alloc(int'(r.request_size), where);
            if (served) begin
                allocs_ok++;
                live_offsets.push_back(where);
            end else begin
                allocs_failed++;
                where = 0;
            end
        end else begin
            served = release_block(int'(r.block_offset));
            if (served) frees_ok++;
            else frees_ignored++;
        end
        rsp.ok             = served;
        rsp.payload_offset = OFFS_W'(where);
        return rsp;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_bfa_req alloc_req(int size);
        t_bfa_req r;
        r.operation    = OP_ALLOC;
        r.request_size = SIZE_W'(size);
        r.block_offset = '0;
        return r;
    endfunction

    function automatic t_bfa_req free_req(int offset);
        t_bfa_req r;
        r.operation    = OP_FREE;
        r.request_size = '0;
        r.block_offset = OFFS_W'(offset);
        return r;
    endfunction

    // Mostly back to back, often a short pause, now and then a long one.
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet_mode || roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int stall_length();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sizes lean towards small blocks so the pool fragments and the walks
    // stay reasonably short; the rest covers zero, the whole pool and the
    // full field range.
    function automatic int random_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3) return 0;
        if (roll < 6) return pool_len - 2 * HDR_BYTES - $urandom_range(0, 2);
        if (roll < 70) return $urandom_range(1, 24);
        if (roll < 92) return $urandom_range(25, 200);
        return $urandom_range(1, 4095);
    endfunction

    // Mostly well-formed traffic: allocations and frees of live blocks. The
    // rest are frees of arbitrary or slightly wrong offsets. The field that
    // an operation ignores carries random bits.
    function automatic t_bfa_req random_request();
        t_bfa_req r;
        int       roll;
        int       pick;
        roll           = $urandom_range(0, 99);
        r.request_size = SIZE_W'($urandom_range(0, 4095));
        r.block_offset = OFFS_W'($urandom_range(0, 4095));
        if (roll < 40 && live_offsets.size() != 0) begin
            pick           = $urandom_range(0, live_offsets.size() - 1);
            r.operation    = OP_FREE;
            r.block_offset = OFFS_W'(live_offsets[pick]);
        end else if (roll < 48) begin
            r.operation = OP_FREE;
            if (roll < 44 && live_offsets.size() != 0) begin
                pick           = $urandom_range(0, live_offsets.size() - 1);
                r.block_offset = OFFS_W'(live_offsets[pick] + 1);
            end
        end else begin
            r.operation    = OP_ALLOC;
            r.request_size = SIZE_W'(random_size());
        end
        return r;
    endfunction

    // Offers one transaction and returns at the edge where it is accepted.
    // Valid stays high on return, so a following call with no gap keeps the
    // channel busy without a dip; anything that waits must lower it first.
    task automatic send_request(input t_bfa_req r);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        do @(posedge clk); while (in_stall);
        pending_rsp.push_back(predict_response(r));
    endtask

    // Every request yields exactly one response, so once nothing is owed the
    // block is idle; the settle time then catches any stray response.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_pool_size(input logic [CFG_W-1:0] bytes);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= bytes;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        restart_pool(bytes);
        pool_writes++;
    endtask

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatches++;
        // The count keeps going; the print stops so a broken block cannot
        // flood the log.
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH response %0d: %s expected %0d, got %0d",
                     results_seen, what, want, got);
    endtask

    // ------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------

    // The response stall is random in short bursts with the odd long one,
    // except while a hold-off is running, when it stays high throughout.
    initial begin : out_stall_driver
        int burst;
        burst = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_left > 0) begin
                hold_off_left--;
                out_stall <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                out_stall <= 1'b1;
            end else if (!quiet_mode && $urandom_range(0, 99) < 25) begin
                burst = stall_length() - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Each accepted response is matched against the oldest one owed.
    always @(posedge clk) begin : response_checker
        t_bfa_rsp want;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (pending_rsp.size() == 0) begin
                report_mismatch("response with nothing owed, ok", -1, int'(out_rsp.ok));
            end else begin
                want = pending_rsp.pop_front();
                if (out_rsp.ok !== want.ok)
                    report_mismatch("ok", int'(want.ok), int'(out_rsp.ok));
                if (out_rsp.payload_offset !== want.payload_offset)
                    report_mismatch("payload_offset", int'(want.payload_offset),
                                    int'(out_rsp.payload_offset));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, the exact-fit boundary, bad and repeated frees, best
    // fit among several holes and merging through to the end of the pool.
    task automatic test_alloc_free_edges();
        send_request(alloc_req(0));       // zero size never succeeds
        send_request(alloc_req(4095));
        send_request(alloc_req(4088));    // payload plus header equals the block
        send_request(alloc_req(4087));    // one byte less fits, leaving a 1-byte tail
        send_request(free_req(4));        // merges with the tail
        send_request(free_req(4));        // already free, still served
        send_request(free_req(0));        // would put the header before the pool
        send_request(free_req(4095));     // no header there
        send_request(alloc_req(12));
        send_request(alloc_req(2));
        send_request(alloc_req(6));
        send_request(alloc_req(2));
        send_request(free_req(4));        // leaves a 12-byte hole
        send_request(free_req(26));       // leaves a 6-byte hole
        send_request(alloc_req(1));       // the 6-byte hole is the best fit
        send_request(free_req(20));       // merges into the hole in front
        send_request(free_req(36));       // merges through to the pool end
    endtask

    // The smallest pool, and sizes written below and above the legal range.
    task automatic test_pool_size_limits();
        set_pool_size(POOL_MIN);
        send_request(alloc_req(7));
        send_request(alloc_req(1));       // only a 1-byte tail is left
        send_request(free_req(4));
        set_pool_size(13'd0);             // clamps up to the minimum
        send_request(alloc_req(8));
        set_pool_size(13'h1FFF);          // clamps down to the full pool
        send_request(alloc_req(4087));
    endtask

    // The response side holds off for a long stretch while requests keep
    // coming, so the block fills and has to stall its input.
    task automatic test_backpressure();
        set_pool_size(13'd512);
        quiet_mode    = 1'b1;
        hold_off_left = 400;
        repeat (24) send_request(random_request());
        quiet_mode = 1'b0;
        wait_drained();
    endtask

    // Random traffic over a range of pool sizes, one phase without idling.
    task automatic test_random_traffic();
        logic [CFG_W-1:0] bytes;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       bytes = POOL_RESET;
                1:       bytes = 13'd1000;
                2:       bytes = 13'd257;
                3:       bytes = POOL_MIN;
                4:       bytes = 13'd77;
                5:       bytes = 13'd8000;
                default: bytes = 13'd2048;
            endcase
            set_pool_size(bytes);
            quiet_mode = (ph == 2);
            repeat (RANDOM_ITEMS / PHASES) send_request(random_request());
            quiet_mode = 1'b0;
        end
    endtask

    initial begin : stimulus
        in_valid    <= 1'b0;
        in_req      <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        rst_n       <= 1'b0;
        restart_pool(POOL_RESET);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_alloc_free_edges();
        test_pool_size_limits();
        test_backpressure();
        test_random_traffic();
        wait_drained();

        $display("Checked %0d responses: %0d allocations served, %0d refused, %0d frees done, %0d ignored.",
                 results_seen, allocs_ok, allocs_failed, frees_ok, frees_ignored);
        $display("Pool size rewritten %0d times, from the minimum to beyond the maximum.",
                 pool_writes);
        if (mismatches == 0) begin
            $display("PASS best_fit_block_allocator");
        end else begin
            $display("FAIL best_fit_block_allocator");
        end
        $finish;
    end

endmodule

FILE: best_fit_block_allocator.f
hdl/bfa_pkg.sv
hdl/bfa_header_ram.sv
hdl/best_fit_block_allocator.sv
hdl/bfa_checker.sv
dv/tb_best_fit_block_allocator.sv
